### design/fect_pkg.sv
// ----------------------------------------------------------------------------
// fect_pkg
// Shared types and constants for the free extent coalescing table.
// ----------------------------------------------------------------------------
package fect_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_BITS   = 16;
	localparam int SIZE_W      = ADDR_BITS + 1;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [SIZE_W-1:0] SPACE_END = SIZE_W'(1) << ADDR_BITS;

	typedef enum logic [2:0] {
		ST_INSERTED   = 3'd0,
		ST_JOIN_LOWER = 3'd1,
		ST_JOIN_UPPER = 3'd2,
		ST_JOIN_BOTH  = 3'd3,
		ST_REJECTED   = 3'd4,
		ST_FULL       = 3'd5,
		ST_LIST_ENTRY = 3'd6,
		ST_LIST_EMPTY = 3'd7
	} status_t;

	localparam logic FUNC_RELEASE = 1'b0;
	localparam logic FUNC_LIST    = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [ADDR_BITS-1:0] block_start;
		logic [ADDR_BITS-1:0] block_size;
	} in_item_t;

	typedef struct packed {
		status_t              status;
		logic [ADDR_BITS-1:0] block_start_res;
		logic [SIZE_W-1:0]    block_size_res;
		logic                 last;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [SIZE_W-1:0]    size;
	} entry_t;

endpackage

### design/fect_ram.sv
// ----------------------------------------------------------------------------
// fect_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fect_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/free_extent_coalescing_table.sv
// ----------------------------------------------------------------------------
// free_extent_coalescing_table
// Address-sorted table of free extents that merges released blocks with
// their neighbors and lists the table on request.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Beat
//   in        in_valid, in_ready, in_data      one release or list request
//   out       out_valid, out_ready, out_data   one status or listed extent
//
// A release is accepted, each stored extent is scanned by a read and a check
// state, and a decide state follows. Entries are moved by a read and a write
// state each when an extent is inserted or two extents are joined; then an
// inserted extent is written and the status beat is loaded. A rejected release
// skips the decision. A list request is accepted, then each extent is read and
// sent, or a status beat goes out on an empty table; the RAM has one read port.
// Reset empties the table at once. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module free_extent_coalescing_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fect_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fect_pkg::out_item_t out_data
);
	import fect_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DECIDE,
		S_SHD_RD,
		S_SHD_WR,
		S_SHU_RD,
		S_SHU_WR,
		S_PLACE,
		S_LS_RD,
		S_LS_OUT,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     pos_q;
	logic [ADDR_BITS-1:0] s_q;
	logic [ADDR_BITS-1:0] z_q;
	logic [SIZE_W-1:0]    e_q;
	logic [ADDR_BITS-1:0] lo_start_q;
	logic [SIZE_W-1:0]    lo_size_q;
	logic [SIZE_W-1:0]    lo_end_q;
	logic                 hi_found_q;
	logic [ADDR_BITS-1:0] hi_start_q;
	logic [SIZE_W-1:0]    hi_size_q;
	out_item_t            res_q;
	out_item_t            out_q;
	logic                 out_valid_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	entry_t               ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;
	entry_t               ram_rdata;

	logic [SIZE_W-1:0]    in_end;
	logic [SIZE_W-1:0]    rd_end;
	logic                 rd_overlap;
	logic                 join_lo;
	logic                 join_hi;
	logic [SIZE_W-1:0]    z_ext;
	logic [SIZE_W-1:0]    both_size;
	logic                 out_free;
	logic                 out_load;
	logic [CNT_W-1:0]     idx_inc;
	logic [CNT_W-1:0]     idx_dec;
	logic [CNT_W-1:0]     pos_dec;

	fect_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_end     = {1'b0, in_data.block_start} + {1'b0, in_data.block_size};
	assign rd_end     = {1'b0, ram_rdata.start} + ram_rdata.size;
	assign rd_overlap = ({1'b0, s_q} < rd_end) && ({1'b0, ram_rdata.start} < e_q);
	assign join_lo    = (pos_q != '0) && (lo_end_q == {1'b0, s_q});
	assign join_hi    = hi_found_q && ({1'b0, hi_start_q} == e_q);
	assign z_ext      = {1'b0, z_q};
	assign both_size  = lo_size_q + z_ext + hi_size_q;
	assign out_free   = !out_valid_q || out_ready;
	assign out_load   = ((state_q == S_DONE) && out_free) || (state_q == S_LS_OUT);
	assign idx_inc    = idx_q + CNT_W'(1);
	assign idx_dec    = idx_q - CNT_W'(1);
	assign pos_dec    = pos_q - CNT_W'(1);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_SHU_RD: begin
				ram_raddr = idx_dec[IDX_W-1:0];
			end
			S_SHU_WR: begin
				ram_we = 1'b1;
			end
			S_SHD_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_dec[IDX_W-1:0];
			end
			S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IDX_W-1:0];
				ram_wdata = '{start: s_q, size: z_ext};
			end
			S_DECIDE: begin
				if (join_lo && join_hi) begin
					ram_we    = 1'b1;
					ram_waddr = pos_dec[IDX_W-1:0];
					ram_wdata = '{start: lo_start_q, size: both_size};
				end else if (join_lo) begin
					ram_we    = 1'b1;
					ram_waddr = pos_dec[IDX_W-1:0];
					ram_wdata = '{start: lo_start_q, size: lo_size_q + z_ext};
				end else if (join_hi) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[IDX_W-1:0];
					ram_wdata = '{start: s_q, size: hi_size_q + z_ext};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						s_q        <= in_data.block_start;
						z_q        <= in_data.block_size;
						e_q        <= in_end;
						idx_q      <= '0;
						pos_q      <= '0;
						hi_found_q <= 1'b0;
						if (in_data.func == FUNC_LIST) begin
							if (cnt_q == '0) begin
								res_q   <= '{status: ST_LIST_EMPTY, block_start_res: '0,
								             block_size_res: '0, last: 1'b1};
								state_q <= S_DONE;
							end else begin
								state_q <= S_LS_RD;
							end
						end else if (in_data.block_size == '0 || in_end > SPACE_END) begin
							res_q   <= '{status: ST_REJECTED, block_start_res: '0,
							             block_size_res: '0, last: 1'b1};
							state_q <= S_DONE;
						end else if (cnt_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (rd_overlap) begin
						res_q   <= '{status: ST_REJECTED, block_start_res: '0,
						             block_size_res: '0, last: 1'b1};
						state_q <= S_DONE;
					end else begin
						if (ram_rdata.start < s_q) begin
							pos_q      <= idx_inc;
							lo_start_q <= ram_rdata.start;
							lo_size_q  <= ram_rdata.size;
							lo_end_q   <= rd_end;
						end else if (!hi_found_q) begin
							hi_found_q <= 1'b1;
							hi_start_q <= ram_rdata.start;
							hi_size_q  <= ram_rdata.size;
						end
						idx_q   <= idx_inc;
						state_q <= (idx_inc == cnt_q) ? S_DECIDE : S_SCAN_RD;
					end
				end
				S_DECIDE: begin
					if (join_lo && join_hi) begin
						res_q <= '{status: ST_JOIN_BOTH, block_start_res: lo_start_q,
						           block_size_res: both_size, last: 1'b1};
						if (pos_q + CNT_W'(1) < cnt_q) begin
							idx_q   <= pos_q + CNT_W'(1);
							state_q <= S_SHD_RD;
						end else begin
							cnt_q   <= cnt_q - CNT_W'(1);
							state_q <= S_DONE;
						end
					end else if (join_lo) begin
						res_q   <= '{status: ST_JOIN_LOWER, block_start_res: lo_start_q,
						             block_size_res: lo_size_q + z_ext, last: 1'b1};
						state_q <= S_DONE;
					end else if (join_hi) begin
						res_q   <= '{status: ST_JOIN_UPPER, block_start_res: s_q,
						             block_size_res: hi_size_q + z_ext, last: 1'b1};
						state_q <= S_DONE;
					end else if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
						res_q   <= '{status: ST_FULL, block_start_res: '0,
						             block_size_res: '0, last: 1'b1};
						state_q <= S_DONE;
					end else begin
						res_q <= '{status: ST_INSERTED, block_start_res: s_q,
						           block_size_res: z_ext, last: 1'b1};
						if (cnt_q > pos_q) begin
							idx_q   <= cnt_q;
							state_q <= S_SHU_RD;
						end else begin
							state_q <= S_PLACE;
						end
					end
				end
				S_SHD_RD: begin
					state_q <= S_SHD_WR;
				end
				S_SHD_WR: begin
					if (idx_inc == cnt_q) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_SHD_RD;
					end
				end
				S_SHU_RD: begin
					state_q <= S_SHU_WR;
				end
				S_SHU_WR: begin
					if (idx_dec == pos_q) begin
						state_q <= S_PLACE;
					end else begin
						idx_q   <= idx_dec;
						state_q <= S_SHU_RD;
					end
				end
				S_PLACE: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_LS_RD: begin
					if (out_free) begin
						state_q <= S_LS_OUT;
					end
				end
				S_LS_OUT: begin
					out_q       <= '{status: ST_LIST_ENTRY, block_start_res: ram_rdata.start,
					                 block_size_res: ram_rdata.size,
					                 last: (idx_inc == cnt_q)};
					out_valid_q <= 1'b1;
					idx_q       <= idx_inc;
					state_q     <= (idx_inc == cnt_q) ? S_IDLE : S_LS_RD;
				end
				S_DONE: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/sv/free_extent_coalescing_table_tb.sv
// ----------------------------------------------------------------------------
// free_extent_coalescing_table_tb
// Self-checking bench for the free extent table. A directed table walks the
// empty list, zero-size and past-the-top releases, every merge case, front
// insertion, overlap rejection and the full table. Random releases aimed at
// the stored extents follow, with random stalls on both channels. A closing
// sweep then fills every gap so the table becomes one extent. Every beat is
// checked against a behavioral copy of the table or a planned result.
// ----------------------------------------------------------------------------
module free_extent_coalescing_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fect_pkg::*;

	localparam int SPACE_TOP = 1 << ADDR_BITS;

	typedef enum int {GROW_UP, GROW_DOWN, BRIDGE, SPLIT_GAP, CLASH} shape_t;

	typedef struct packed {
		in_item_t  req;
		logic [7:0]  reps;
		logic [15:0] stride;
		logic        typed;
		out_item_t   want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int ext_start [TABLE_DEPTH];
	int ext_size [TABLE_DEPTH];
	int ext_count = 0;

	out_item_t fresh_results[$];
	out_item_t pending_results[$];
	out_item_t head_result;
	int        mismatches = 0;
	int        send_idle = 29;
	int        recv_idle = 65;

	free_extent_coalescing_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	function automatic in_item_t mkreq(logic f, int s, int z);
		in_item_t r;
		r.func = f;
		r.block_start = 16'(s);
		r.block_size = 16'(z);
		return r;
	endfunction

	function automatic out_item_t mkres(status_t st, int a, int z, logic last);
		out_item_t r;
		r.status = st;
		r.block_start_res = 16'(a);
		r.block_size_res = 17'(z);
		r.last = last;
		return r;
	endfunction

	function automatic void table_step(in_item_t req);
		int s;
		int z;
		int e;
		int pos;
		int pe;
		bit lo;
		bit hi;
		fresh_results.delete();
		if (req.func == FUNC_LIST) begin
			if (ext_count == 0)
				fresh_results.push_back(mkres(ST_LIST_EMPTY, 0, 0, 1'b1));
			for (int i = 0; i < ext_count; i++)
				fresh_results.push_back(mkres(ST_LIST_ENTRY, ext_start[i], ext_size[i],
					i == ext_count - 1));
			return;
		end
		s = int'(req.block_start);
		z = int'(req.block_size);
		e = s + z;
		pos = 0;
		if (z == 0 || e > SPACE_TOP) begin
			fresh_results.push_back(mkres(ST_REJECTED, 0, 0, 1'b1));
			return;
		end
		for (int i = 0; i < ext_count; i++) begin
			pe = ext_start[i] + ext_size[i];
			if (s < pe && ext_start[i] < e) begin
				fresh_results.push_back(mkres(ST_REJECTED, 0, 0, 1'b1));
				return;
			end
			if (ext_start[i] < s)
				pos = i + 1;
		end
		lo = pos > 0 && ext_start[pos - 1] + ext_size[pos - 1] == s;
		hi = pos < ext_count && ext_start[pos] == e;
		if (lo && hi) begin
			ext_size[pos - 1] = ext_size[pos - 1] + z + ext_size[pos];
			for (int i = pos; i + 1 < ext_count; i++) begin
				ext_start[i] = ext_start[i + 1];
				ext_size[i] = ext_size[i + 1];
			end
			ext_count--;
			fresh_results.push_back(mkres(ST_JOIN_BOTH, ext_start[pos - 1],
				ext_size[pos - 1], 1'b1));
		end else if (lo) begin
			ext_size[pos - 1] = ext_size[pos - 1] + z;
			fresh_results.push_back(mkres(ST_JOIN_LOWER, ext_start[pos - 1],
				ext_size[pos - 1], 1'b1));
		end else if (hi) begin
			ext_start[pos] = s;
			ext_size[pos] = ext_size[pos] + z;
			fresh_results.push_back(mkres(ST_JOIN_UPPER, s, ext_size[pos], 1'b1));
		end else if (ext_count >= TABLE_DEPTH) begin
			fresh_results.push_back(mkres(ST_FULL, 0, 0, 1'b1));
		end else begin
			for (int i = ext_count; i > pos; i--) begin
				ext_start[i] = ext_start[i - 1];
				ext_size[i] = ext_size[i - 1];
			end
			ext_start[pos] = s;
			ext_size[pos] = z;
			ext_count++;
			fresh_results.push_back(mkres(ST_INSERTED, s, z, 1'b1));
		end
	endfunction

	// Most releases are aimed at a stored extent so merges, overlaps and a full
	// table recur; the rest are lists, raw noise, zero-size and past-top releases.
	function automatic in_item_t random_request();
		int pick;
		int i;
		int lo_end;
		int hi;
		int gap;
		int below;
		int s;
		int z;
		shape_t shape;
		pick = $urandom_range(99);
		s = $urandom_range(65535);
		z = $urandom_range(1, 16);
		if (pick < 8)
			return mkreq(FUNC_LIST, $urandom, $urandom);
		if (pick < 18)
			return mkreq(FUNC_RELEASE, $urandom, $urandom);
		if (pick < 24) begin
			s = $urandom_range(1024, 65535);
			z = (pick < 21) ? 0 : SPACE_TOP - s + $urandom_range(1, 1000);
		end else if (ext_count > 0) begin
			i = $urandom_range(ext_count - 1);
			lo_end = ext_start[i] + ext_size[i];
			hi = (i + 1 < ext_count) ? ext_start[i + 1] : SPACE_TOP;
			gap = hi - lo_end;
			below = ext_start[i] - ((i > 0) ? ext_start[i - 1] + ext_size[i - 1] : 0);
			shape = shape_t'($urandom_range(4));
			case (shape)
				GROW_UP: if (gap >= 2) begin
					s = lo_end;
					z = $urandom_range(1, (gap - 1 < 32) ? gap - 1 : 32);
				end
				GROW_DOWN: if (below >= 2) begin
					z = $urandom_range(1, (below - 1 < 32) ? below - 1 : 32);
					s = ext_start[i] - z;
				end
				BRIDGE: if (i + 1 < ext_count && gap >= 1 && gap <= 512) begin
					s = lo_end;
					z = gap;
				end
				SPLIT_GAP: if (gap >= 3) begin
					s = lo_end + $urandom_range(1, (gap - 2 < 300) ? gap - 2 : 300);
					z = $urandom_range(1, (hi - s - 1 < 16) ? hi - s - 1 : 16);
				end
				CLASH: begin
					s = ext_start[i] + $urandom_range(0, ext_size[i] - 1);
					z = $urandom_range(1, 64);
				end
			endcase
		end
		return mkreq(FUNC_RELEASE, s, z);
	endfunction

	task automatic send_request(in_item_t req, logic typed, out_item_t want);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		table_step(req);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (fresh_results[k])
				pending_results.push_back(fresh_results[k]);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat status %0d start %h size %h last %b",
					$time, out_data.status, out_data.block_start_res,
					out_data.block_size_res, out_data.last);
			end else begin
				head_result = pending_results.pop_front();
				if (out_data !== head_result) begin
					mismatches++;
					$display("%0t: expected status %0d start %h size %h last %b, ",
						$time, head_result.status, head_result.block_start_res,
						head_result.block_size_res, head_result.last,
						"got status %0d start %h size %h last %b", out_data.status,
						out_data.block_start_res, out_data.block_size_res, out_data.last);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		plan_row_t plan [16];
		in_item_t  sweep[$];
		int        cursor;
		plan = '{
			'{mkreq(FUNC_LIST, 0, 0), 8'd1, 16'd0, 1'b1, mkres(ST_LIST_EMPTY, 0, 0, 1'b1)},
			'{mkreq(FUNC_RELEASE, 'h1000, 0), 8'd1, 16'd0, 1'b1,
				mkres(ST_REJECTED, 0, 0, 1'b1)},
			'{mkreq(FUNC_RELEASE, 'hFFFF, 2), 8'd1, 16'd0, 1'b1,
				mkres(ST_REJECTED, 0, 0, 1'b1)},
			'{mkreq(FUNC_RELEASE, 'hFFFF, 1), 8'd1, 16'd0, 1'b1,
				mkres(ST_INSERTED, 'hFFFF, 1, 1'b1)},
			'{mkreq(FUNC_RELEASE, 'h2000, 'h100), 8'd1, 16'd0, 1'b1,
				mkres(ST_INSERTED, 'h2000, 'h100, 1'b1)},
			'{mkreq(FUNC_RELEASE, 'h2100, 'h80), 8'd1, 16'd0, 1'b0, '0},
			'{mkreq(FUNC_RELEASE, 'h1F00, 'h100), 8'd1, 16'd0, 1'b0, '0},
			'{mkreq(FUNC_RELEASE, 'h3000, 'h10), 8'd1, 16'd0, 1'b0, '0},
			'{mkreq(FUNC_RELEASE, 'h2180, 'hE80), 8'd1, 16'd0, 1'b0, '0},
			'{mkreq(FUNC_RELEASE, 'h0000, 'h10), 8'd1, 16'd0, 1'b0, '0},
			'{mkreq(FUNC_RELEASE, 'h2500, 'h10), 8'd1, 16'd0, 1'b1,
				mkres(ST_REJECTED, 0, 0, 1'b1)},
			'{mkreq(FUNC_RELEASE, 'h0000, 'hFFFF), 8'd1, 16'd0, 1'b1,
				mkres(ST_REJECTED, 0, 0, 1'b1)},
			'{mkreq(FUNC_RELEASE, 'h4000, 'h10), 8'd13, 16'h100, 1'b0, '0},
			'{mkreq(FUNC_RELEASE, 'h9000, 'h10), 8'd1, 16'd0, 1'b1,
				mkres(ST_FULL, 0, 0, 1'b1)},
			'{mkreq(FUNC_RELEASE, 'h4010, 'h8), 8'd1, 16'd0, 1'b0, '0},
			'{mkreq(FUNC_LIST, 0, 0), 8'd1, 16'd0, 1'b0, '0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r])
			for (int k = 0; k < plan[r].reps; k++)
				send_request(mkreq(plan[r].req.func,
					int'(plan[r].req.block_start) + k * int'(plan[r].stride),
					int'(plan[r].req.block_size)), plan[r].typed, plan[r].want);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 29 : (phase == 1) ? 65 : 0;
			recv_idle = (phase == 0) ? 65 : (phase == 1) ? 29 : 0;
			repeat (145)
				send_request(random_request(), 1'b0, '0);
			if (phase == 0) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
		end

		// Release every remaining hole so the table collapses into one extent
		// covering the whole address space.
		cursor = 0;
		for (int i = 0; i < ext_count; i++) begin
			if (ext_start[i] > cursor)
				sweep.push_back(mkreq(FUNC_RELEASE, cursor, ext_start[i] - cursor));
			cursor = ext_start[i] + ext_size[i];
		end
		if (cursor < SPACE_TOP)
			sweep.push_back(mkreq(FUNC_RELEASE, cursor, SPACE_TOP - cursor));
		foreach (sweep[k])
			send_request(sweep[k], 1'b0, '0);
		send_request(mkreq(FUNC_LIST, 0, 0), 1'b0, '0);
		send_request(mkreq(FUNC_RELEASE, 'h1234, 1), 1'b0, '0);

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (150) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
